@@ rtl/coaprp_pkg.sv @@
package coaprp_pkg;

	localparam int unsigned HEADER_BYTES    = 4;
	localparam int unsigned MAX_TOKEN_BYTES = 8;

	localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;
	localparam logic [1:0] COAP_VERSION   = 2'b01;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_VER   = 2'd1;
	localparam logic [1:0] ST_BAD_TKL   = 2'd2;
	localparam logic [1:0] ST_TOO_SHORT = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_frame;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [15:0] message_id;
		logic [63:0] token_value;
		logic [3:0]  token_count;
		logic [1:0]  status;
		logic        last_result;
	} result_t;

endpackage

@@ rtl/coaprp_stream_if.sv @@
interface coaprp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/coap_reply_parser_unit.sv @@
// The results of a byte are written into a registered result queue and appear on tx once they reach its head.
// Throughput: one byte per cycle while rx is ready; the parser state is updated once per byte.
// A four-entry result queue decouples tx; rx stalls while more than two results wait,
// so a final payload byte, which yields a payload result and a summary, finds room for both.
// Reset (arst_n low, asynchronous) returns the parser to the first header byte and
// empties the result queue.
module coap_reply_parser_unit (
	input logic              clk,
	input logic              arst_n,
	coaprp_stream_if.sink    rx,
	coaprp_stream_if.source  tx
);

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR,
		PH_TOKEN,
		PH_OPT,
		PH_SKIP,
		PH_PAYLOAD,
		PH_DISCARD
	} phase_t;

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	phase_t      phase_q, phase_d;
	logic [3:0]  pos_q, pos_d, pos_inc;
	logic [3:0]  tkl_q, tkl_d;
	logic [3:0]  skip_q, skip_d;
	logic [15:0] id_q, id_d;
	logic [63:0] token_q, token_d;
	logic [1:0]  err_q, err_d;

	coaprp_pkg::result_t fifo_q [DEPTH];
	logic [PTR_W-1:0]    wr_q, rd_q;
	logic [CNT_W-1:0]    count_q;

	coaprp_pkg::in_item_t item;
	coaprp_pkg::result_t  res0, res1, summary;
	logic [1:0]           push_n;
	logic [1:0]           st;
	logic                 in_fire, out_fire;

	assign item     = rx.payload;
	assign rx.ready = (count_q <= CNT_W'(DEPTH - 2));
	assign in_fire  = rx.valid && rx.ready;
	assign tx.valid = (count_q != '0);
	assign tx.payload = fifo_q[rd_q];
	assign out_fire = tx.valid && tx.ready;

	assign pos_inc = pos_q + 4'd1;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		tkl_d   = tkl_q;
		skip_d  = skip_q;
		id_d    = id_q;
		token_d = token_q;
		err_d   = err_q;
		unique case (phase_q)
			PH_HDR0: begin
				tkl_d = item.data_byte[3:0];
				if (item.data_byte[7:6] != coaprp_pkg::COAP_VERSION) begin
					err_d   = coaprp_pkg::ST_BAD_VER;
					phase_d = PH_DISCARD;
				end else if (item.data_byte[3:0] > 4'(coaprp_pkg::MAX_TOKEN_BYTES)) begin
					err_d   = coaprp_pkg::ST_BAD_TKL;
					phase_d = PH_DISCARD;
				end else begin
					pos_d   = 4'd1;
					phase_d = PH_HDR;
				end
			end
			PH_HDR: begin
				if (pos_q == 4'd2) begin
					id_d[15:8] = item.data_byte;
				end else if (pos_q == 4'd3) begin
					id_d[7:0] = item.data_byte;
				end
				if (pos_inc >= 4'(coaprp_pkg::HEADER_BYTES)) begin
					pos_d   = 4'd0;
					phase_d = (tkl_q == 4'd0) ? PH_OPT : PH_TOKEN;
				end else begin
					pos_d = pos_inc;
				end
			end
			PH_TOKEN: begin
				token_d = {token_q[55:0], item.data_byte};
				pos_d   = pos_inc;
				if (pos_inc >= tkl_q) begin
					phase_d = PH_OPT;
				end
			end
			PH_OPT: begin
				if (item.data_byte == coaprp_pkg::PAYLOAD_MARKER) begin
					phase_d = PH_PAYLOAD;
				end else begin
					skip_d = item.data_byte[3:0];
					if (item.data_byte[3:0] != 4'd0) begin
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				skip_d = skip_q - 4'd1;
				if (skip_q == 4'd1) begin
					phase_d = PH_OPT;
				end
			end
			default: begin
			end
		endcase
	end

	// The summary reflects the state after this byte has been taken in.
	always_comb begin
		st = err_d;
		if (st == coaprp_pkg::ST_OK &&
		    (phase_d == PH_HDR0 || phase_d == PH_HDR || phase_d == PH_TOKEN)) begin
			st = coaprp_pkg::ST_TOO_SHORT;
		end
		summary             = '0;
		summary.kind        = coaprp_pkg::KIND_SUMMARY;
		summary.last_result = 1'b1;
		summary.status      = st;
		if (st == coaprp_pkg::ST_OK) begin
			summary.message_id  = id_d;
			summary.token_value = token_d;
			summary.token_count = tkl_d;
		end

		res0   = summary;
		res1   = summary;
		push_n = 2'd0;
		if (phase_q == PH_PAYLOAD) begin
			res0              = '0;
			res0.kind         = coaprp_pkg::KIND_PAYLOAD;
			res0.payload_byte = item.data_byte;
			push_n            = item.end_of_frame ? 2'd2 : 2'd1;
		end else if (item.end_of_frame) begin
			push_n = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			pos_q   <= '0;
			tkl_q   <= '0;
			skip_q  <= '0;
			id_q    <= '0;
			token_q <= '0;
			err_q   <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (in_fire) begin
				if (item.end_of_frame) begin
					phase_q <= PH_HDR0;
					pos_q   <= '0;
					tkl_q   <= '0;
					skip_q  <= '0;
					id_q    <= '0;
					token_q <= '0;
					err_q   <= '0;
				end else begin
					phase_q <= phase_d;
					pos_q   <= pos_d;
					tkl_q   <= tkl_d;
					skip_q  <= skip_d;
					id_q    <= id_d;
					token_q <= token_d;
					err_q   <= err_d;
				end
				wr_q <= wr_q + PTR_W'(push_n);
			end
			if (out_fire) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			count_q <= count_q + (in_fire ? CNT_W'(push_n) : CNT_W'(0))
			         - (out_fire ? CNT_W'(1) : CNT_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && push_n != 2'd0) begin
			fifo_q[wr_q] <= res0;
		end
		if (in_fire && push_n == 2'd2) begin
			fifo_q[wr_q + PTR_W'(1)] <= res1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("result queue overflow");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && item.end_of_frame |=> phase_q == PH_HDR0 && err_q == coaprp_pkg::ST_OK)
		else $error("parser did not restart after final byte");

	a_discard_err: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DISCARD |-> err_q != coaprp_pkg::ST_OK)
		else $error("discard phase without an error code");

	a_last_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid |-> tx.payload.last_result == tx.payload.kind)
		else $error("last_result does not match result kind");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.payload.kind == coaprp_pkg::KIND_SUMMARY &&
		tx.payload.status != coaprp_pkg::ST_OK |-> tx.payload.token_count == 4'd0 &&
		tx.payload.message_id == 16'd0)
		else $error("error summary carries token or message ID");

endmodule
